// ===== rtl/sha1md_pkg.sv =====
// Shared constants, types and control struct of the SHA-1 digest block.
`timescale 1ns / 1ps

package sha1md_pkg;

    localparam int WORD_W  = 32;
    localparam int WIN_N   = 16;
    localparam int CHAIN_N = 5;

    // Chaining values after restart, H0 at index 0
    localparam logic [CHAIN_N-1:0][WORD_W-1:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // Round constants, one for each group of twenty rounds
    localparam logic [WORD_W-1:0] K_CH  = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_PA1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_PA2 = 32'hCA62C1D6;

    localparam logic [6:0] RND_G1   = 7'd20;
    localparam logic [6:0] RND_G2   = 7'd40;
    localparam logic [6:0] RND_G3   = 7'd60;
    localparam logic [6:0] RND_LAST = 7'd79;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [5:0] POS_LEN  = 6'd56;
    localparam logic [2:0] WIDX_LAST = 3'd4;

    // Control from the sequencer to the datapath
    typedef struct packed {
        logic       push;    // shift one byte into the block window
        logic [7:0] pbyte;   // byte to shift in
        logic [1:0] pos_lo;  // byte lane within the current word
        logic       ld;      // load working words from chain
        logic       step;    // run one round
        logic       fold;    // add working words into chain
        logic       init;    // restore the initial chain
        logic [6:0] rnd;     // round number
        logic [2:0] widx;    // digest word being presented
    } t_ctl;

endpackage

// ===== rtl/sha1md_in_if.sv =====
// Input channel: message bytes and end-of-message marks.
`timescale 1ns / 1ps

interface sha1md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_message, output ready);
endinterface

// ===== rtl/sha1md_out_if.sv =====
// Output channel: digest words.
`timescale 1ns / 1ps

interface sha1md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ===== rtl/sha1_message_digest.sv =====
// Top level of the streaming SHA-1 digest block.
//
//   channel  direction  payload                                 transaction
//   i_msg    sink       data_byte, byte_valid, end_of_message   one message step
//   o_dig    source     digest_word, word_index, last_word      one digest word
//
// A step with a byte packs it into the window; the byte filling a 64-byte block
// starts a compression (80 rounds through the one round unit, then one fold).
// End of message shifts in padding and length one byte a cycle up to the block
// end, with one or two compressions, then presents five digest words.
// Reset (i_rst_n low at a clock edge) restores the initial chain and clears the
// byte count. i_msg.ready is low while a full block compresses, and from end
// of message until the last digest word is taken; o_dig stalls hold the word.
`timescale 1ns / 1ps

module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha1md_in_if.sink    i_msg,
    sha1md_out_if.source o_dig
);

    t_ctl              s_ctl;
    logic [WORD_W-1:0] s_w0;
    logic [WORD_W-1:0] s_word;
    logic              s_in_ready;
    logic              s_out_valid;

    sha1md_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (i_msg.valid && s_in_ready),
        .i_data_byte (i_msg.data_byte),
        .i_byte_valid(i_msg.byte_valid),
        .i_eom       (i_msg.end_of_message),
        .i_out_fire  (s_out_valid && o_dig.ready),
        .o_in_ready  (s_in_ready),
        .o_out_valid (s_out_valid),
        .o_ctl       (s_ctl)
    );

    sha1md_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (s_ctl),
        .o_w0  (s_w0)
    );

    sha1md_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_ctl),
        .i_w     (s_w0),
        .o_word  (s_word)
    );

    // Drive the channels
    assign i_msg.ready       = s_in_ready;
    assign o_dig.valid       = s_out_valid;
    assign o_dig.digest_word = s_word;
    assign o_dig.word_index  = s_ctl.widx;
    assign o_dig.last_word   = (s_ctl.widx == WIDX_LAST);

endmodule

// ===== rtl/sha1md_sched.sv =====
// Block window: byte packing and the rolling 16-word message schedule.
`timescale 1ns / 1ps

module sha1md_sched
    import sha1md_pkg::*;
(
    input  logic              i_clk,
    input  t_ctl              i_ctl,
    output logic [WORD_W-1:0] o_w0
);

    logic [WIN_N-1:0][WORD_W-1:0] r_win;
    logic [23:0]                  r_acc;
    logic [WORD_W-1:0]            s_mix;
    logic [WORD_W-1:0]            s_word;

    // Expand the next schedule word from the window taps
    assign s_mix  = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
    assign s_word = {r_acc, i_ctl.pbyte};
    assign o_w0   = r_win[0];

    // Pack bytes big-endian, push full words; during rounds roll the window
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_acc <= s_word[23:0];
            if (i_ctl.pos_lo == 2'd3) begin
                r_win <= {s_word, r_win[WIN_N-1:1]};
            end
        end else if (i_ctl.step) begin
            r_win <= {{s_mix[WORD_W-2:0], s_mix[WORD_W-1]}, r_win[WIN_N-1:1]};
        end
    end

endmodule

// ===== rtl/sha1md_round.sv =====
// Shared round unit: working words, round function and chaining words.
`timescale 1ns / 1ps

module sha1md_round
    import sha1md_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic [WORD_W-1:0] i_w,
    output logic [WORD_W-1:0] o_word
);

    logic [CHAIN_N-1:0][WORD_W-1:0] r_chain;
    logic [WORD_W-1:0] r_a, r_b, r_c, r_d, r_e;
    logic [WORD_W-1:0] s_f, s_k, s_t;

    // Select round function and constant by round group
    always_comb begin
        if (i_ctl.rnd < RND_G1) begin
            s_f = (r_b & r_c) | (~r_b & r_d);
            s_k = K_CH;
        end else if (i_ctl.rnd < RND_G2) begin
            s_f = r_b ^ r_c ^ r_d;
            s_k = K_PA1;
        end else if (i_ctl.rnd < RND_G3) begin
            s_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            s_k = K_MAJ;
        end else begin
            s_f = r_b ^ r_c ^ r_d;
            s_k = K_PA2;
        end
    end

    assign s_t = {r_a[WORD_W-6:0], r_a[WORD_W-1:WORD_W-5]} + s_f + r_e + s_k + i_w;

    // Advance working words one round, or load them from the chain
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_ctl.step) begin
            r_a <= s_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[WORD_W-1:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    // Fold the block result into the chain; restore after each digest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= H_INIT;
        end else if (i_ctl.init) begin
            r_chain <= H_INIT;
        end else if (i_ctl.fold) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
            r_chain[4] <= r_chain[4] + r_e;
        end
    end

    // Pick the digest word on display
    always_comb begin
        unique case (i_ctl.widx)
            3'd0:    o_word = r_chain[0];
            3'd1:    o_word = r_chain[1];
            3'd2:    o_word = r_chain[2];
            3'd3:    o_word = r_chain[3];
            3'd4:    o_word = r_chain[4];
            default: o_word = '0;
        endcase
    end

endmodule

// ===== rtl/sha1md_ctrl.sv =====
// Sequencer: byte position, length count, padding, rounds and digest output.
`timescale 1ns / 1ps

module sha1md_ctrl
    import sha1md_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_fire,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_valid,
    input  logic       i_eom,
    input  logic       i_out_fire,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_ctl       o_ctl
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FOLD  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_pos,   n_pos;
    logic [60:0] r_count, n_count;
    logic [63:0] r_len,   n_len;
    logic        r_mark,  n_mark;
    logic        r_lenph, n_lenph;
    logic        r_pad,   n_pad;
    logic [6:0]  r_rnd,   n_rnd;
    logic [2:0]  r_widx,  n_widx;
    t_ctl        s_ctl;

    // Next-state logic of the sequencer
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_count = r_count;
        n_len   = r_len;
        n_mark  = r_mark;
        n_lenph = r_lenph;
        n_pad   = r_pad;
        n_rnd   = r_rnd;
        n_widx  = r_widx;
        s_ctl        = '0;
        s_ctl.pos_lo = r_pos[1:0];
        s_ctl.rnd    = r_rnd;
        s_ctl.widx   = r_widx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_fire) begin
                    if (i_byte_valid) begin
                        s_ctl.push  = 1'b1;
                        s_ctl.pbyte = i_data_byte;
                        n_count     = r_count + 61'd1;
                    end
                    if (i_eom) begin
                        n_pad = 1'b1;
                        n_len = {n_count, 3'b000};
                    end
                    if (i_byte_valid && r_pos == POS_LAST) begin
                        s_ctl.ld = 1'b1;
                        n_state  = ST_ROUND;
                    end else if (i_eom) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                s_ctl.push = 1'b1;
                if (!r_mark) begin
                    s_ctl.pbyte = PAD_MARK;
                    n_mark      = 1'b1;
                end else if (r_lenph || r_pos == POS_LEN) begin
                    s_ctl.pbyte = r_len[63:56];
                    n_len       = {r_len[55:0], 8'h00};
                    n_lenph     = 1'b1;
                end else begin
                    s_ctl.pbyte = 8'h00;
                end
                if (r_pos == POS_LAST) begin
                    s_ctl.ld = 1'b1;
                    n_state  = ST_ROUND;
                end
            end
            ST_ROUND: begin
                s_ctl.step = 1'b1;
                if (r_rnd == RND_LAST) begin
                    n_rnd   = '0;
                    n_state = ST_FOLD;
                end else begin
                    n_rnd = r_rnd + 7'd1;
                end
            end
            ST_FOLD: begin
                s_ctl.fold = 1'b1;
                if (r_pad && r_lenph) begin
                    n_state = ST_OUT;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (i_out_fire) begin
                    if (r_widx == WIDX_LAST) begin
                        s_ctl.init = 1'b1;
                        n_widx  = '0;
                        n_pos   = '0;
                        n_count = '0;
                        n_mark  = 1'b0;
                        n_lenph = 1'b0;
                        n_pad   = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (s_ctl.push) begin
            n_pos = r_pos + 6'd1;
        end
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_count <= '0;
            r_len   <= '0;
            r_mark  <= 1'b0;
            r_lenph <= 1'b0;
            r_pad   <= 1'b0;
            r_rnd   <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_len   <= n_len;
            r_mark  <= n_mark;
            r_lenph <= n_lenph;
            r_pad   <= n_pad;
            r_rnd   <= n_rnd;
            r_widx  <= n_widx;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_ctl       = s_ctl;

    // Byte packing and window rolling never collide
    a_push_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_ctl.push && s_ctl.step))
        else $error("byte push during a round");

    // Every compression starts at round zero
    a_ld_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctl.ld |=> (r_rnd == '0 && r_state == ST_ROUND))
        else $error("compression did not start at round zero");

    // Compression only starts on a full block
    a_ld_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctl.ld |-> (r_pos == POS_LAST && s_ctl.push))
        else $error("compression started on a partial block");

    // The final digest word restarts the message state
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && i_out_fire && r_widx == WIDX_LAST)
            |=> (r_pos == '0 && r_count == '0 && !r_pad))
        else $error("message state not cleared after digest");

    // Digest is shown only after the length block
    a_out_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_lenph && r_pad && r_pos == '0))
        else $error("digest shown before the length was folded in");

endmodule
